/* design/bcs_pkg.sv */
// Shared types and constants for the battery charger supervisor.
// Holds the sample, configuration and result records, fault codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bcs_pkg;

	// Fault codes reported with each result.
	typedef enum logic [1:0] {
		FLT_NONE = 2'd0,
		FLT_TEMP = 2'd1,
		FLT_TIME = 2'd2,
		FLT_FLOW = 2'd3
	} fault_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_CONNECT_MIN = 3'd0;
	localparam logic [2:0] REG_TEMP_LIMIT  = 3'd1;
	localparam logic [2:0] REG_BAD_CONN    = 3'd2;
	localparam logic [2:0] REG_ROBOT_ON    = 3'd3;
	localparam logic [2:0] REG_ROBOT_OFF   = 3'd4;
	localparam logic [2:0] REG_CUTOFF_MIN  = 3'd5;
	localparam logic [2:0] REG_MAX_CHARGE  = 3'd6;

	// Register values after reset.
	localparam logic [15:0]        RST_CONNECT_MIN = 16'd5000;
	localparam logic signed [11:0] RST_TEMP_LIMIT  = 12'sd600;
	localparam logic [15:0]        RST_BAD_CONN    = 16'd30000;
	localparam logic [14:0]        RST_ROBOT_ON    = 15'd2000;
	localparam logic [14:0]        RST_ROBOT_OFF   = 15'd1000;
	localparam logic [14:0]        RST_CUTOFF_MIN  = 15'd500;
	localparam logic [31:0]        RST_MAX_CHARGE  = 32'd14400000;

	// Configuration registers as seen by the core.
	typedef struct packed {
		logic [15:0]        connect_min_mv;
		logic signed [11:0] temp_limit;
		logic [15:0]        bad_conn_mv;
		logic [14:0]        robot_on_ma;
		logic [14:0]        robot_off_ma;
		logic [14:0]        cutoff_min_ma;
		logic [31:0]        max_charge_ms;
	} cfg_t;

	// One sensor sample.
	typedef struct packed {
		logic [15:0]        voltage_mv;
		logic signed [15:0] current_ma;
		logic signed [11:0] temp_ambient;
		logic signed [11:0] temp_dc;
		logic signed [11:0] temp_pos;
		logic signed [11:0] temp_neg;
		logic [15:0]        elapsed_ms;
	} sample_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  charge_state;
		fault_t      fault_code;
		logic        is_connected;
		logic        is_charging;
		logic        robot_powered;
		logic [31:0] charge_time_ms;
		logic [31:0] connect_time_ms;
	} result_t;

endpackage

/* design/battery_charger_supervisor.sv */
// Top level of the battery charger supervisor: ports, configuration registers,
// input register and output handshake around the supervisor core.
// Depends on bcs_pkg and bcs_core.
//
//  Channel  Handshake                 Payload
//  in       in_valid / in_ready       voltage_mv, current_ma, temp_*, elapsed_ms
//  out      out_valid / out_ready     charge_state, fault_code, flags, timers
//  cfg      cfg_we                    cfg_index, cfg_wdata
//
// One sample per cycle sustained while out_ready is high; a result passes the input
// register, then the state/result register. The two form a two-stage flow; both advance
// together when the result slot is empty or being taken.
// Reset (arst_n low) clears the state and restores the register defaults.
// A stalled output holds its result while one more sample waits in the input register.
`timescale 1ns / 1ps

module battery_charger_supervisor
	import bcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        voltage_mv,
	input  logic signed [15:0] current_ma,
	input  logic signed [11:0] temp_ambient,
	input  logic signed [11:0] temp_dc,
	input  logic signed [11:0] temp_pos,
	input  logic signed [11:0] temp_neg,
	input  logic [15:0]        elapsed_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         charge_state,
	output logic [1:0]         fault_code,
	output logic               is_connected,
	output logic               is_charging,
	output logic               robot_powered,
	output logic [31:0]        charge_time_ms,
	output logic [31:0]        connect_time_ms,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata
);

	cfg_t    cfg_q;
	sample_t smp_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;
	result_t res;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_min_mv <= RST_CONNECT_MIN;
			cfg_q.temp_limit     <= RST_TEMP_LIMIT;
			cfg_q.bad_conn_mv    <= RST_BAD_CONN;
			cfg_q.robot_on_ma    <= RST_ROBOT_ON;
			cfg_q.robot_off_ma   <= RST_ROBOT_OFF;
			cfg_q.cutoff_min_ma  <= RST_CUTOFF_MIN;
			cfg_q.max_charge_ms  <= RST_MAX_CHARGE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONNECT_MIN: cfg_q.connect_min_mv <= cfg_wdata[15:0];
				REG_TEMP_LIMIT:  cfg_q.temp_limit     <= $signed(cfg_wdata[11:0]);
				REG_BAD_CONN:    cfg_q.bad_conn_mv    <= cfg_wdata[15:0];
				REG_ROBOT_ON:    cfg_q.robot_on_ma    <= cfg_wdata[14:0];
				REG_ROBOT_OFF:   cfg_q.robot_off_ma   <= cfg_wdata[14:0];
				REG_CUTOFF_MIN:  cfg_q.cutoff_min_ma  <= cfg_wdata[14:0];
				REG_MAX_CHARGE:  cfg_q.max_charge_ms  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Flow control: the core takes the held sample when the result slot frees up.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register valid and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input payload register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_s1.voltage_mv   <= voltage_mv;
			smp_s1.current_ma   <= current_ma;
			smp_s1.temp_ambient <= temp_ambient;
			smp_s1.temp_dc      <= temp_dc;
			smp_s1.temp_pos     <= temp_pos;
			smp_s1.temp_neg     <= temp_neg;
			smp_s1.elapsed_ms   <= elapsed_ms;
		end
	end

	bcs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.smp     (smp_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// Result ports.
	assign out_valid       = out_valid_q;
	assign charge_state    = res.charge_state;
	assign fault_code      = res.fault_code;
	assign is_connected    = res.is_connected;
	assign is_charging     = res.is_charging;
	assign robot_powered   = res.robot_powered;
	assign charge_time_ms  = res.charge_time_ms;
	assign connect_time_ms = res.connect_time_ms;

endmodule

/* design/bcs_core.sv */
// Supervisor core: connection tracking, timers, fault checks and the charge state machine.
// The state registers are also the result register; they load once per transfer.
// Depends on bcs_pkg.
`timescale 1ns / 1ps

module bcs_core
	import bcs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  sample_t smp,
	input  cfg_t    cfg,
	output result_t res
);

	typedef enum logic [2:0] {
		ST_STANDBY  = 3'd0,
		ST_CHECK    = 3'd1,
		ST_CHARGING = 3'd2,
		ST_CHARGED  = 3'd3,
		ST_ESTOP    = 3'd4,
		ST_BADCONN  = 3'd5
	} mode_t;

	mode_t       mode_q, mode_d, mode_base;
	logic        link_q, link_d;
	logic        robot_q, robot_d;
	fault_t      fault_q, fault_d;
	logic [31:0] charge_q, charge_d;
	logic [31:0] connect_q, connect_d, connect_base;
	logic [15:0] dt;
	logic        now_conn, too_hot, bad_conn, time_over;
	logic signed [16:0] cur_x, robot_on_x, robot_off_x, cutoff_x, thr_x;

	// Adds a 16-bit step to a 32-bit timer, holding at all ones on overflow.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Threshold comparisons on the sample.
	always_comb begin
		now_conn = smp.voltage_mv > cfg.connect_min_mv;
		bad_conn = smp.voltage_mv > cfg.bad_conn_mv;
		too_hot  = (smp.temp_ambient > cfg.temp_limit) || (smp.temp_dc > cfg.temp_limit) ||
			(smp.temp_pos > cfg.temp_limit) || (smp.temp_neg > cfg.temp_limit);
		cur_x       = {smp.current_ma[15], smp.current_ma};
		robot_on_x  = $signed({2'b00, cfg.robot_on_ma});
		robot_off_x = $signed({2'b00, cfg.robot_off_ma});
		cutoff_x    = $signed({2'b00, cfg.cutoff_min_ma});
		thr_x       = robot_q ? robot_on_x : robot_off_x;
	end

	// Connection edges and timer updates, then the fault checks and the machine.
	always_comb begin
		link_d       = link_q;
		mode_base    = mode_q;
		connect_base = connect_q;
		dt           = smp.elapsed_ms;
		if (now_conn && !link_q) begin
			link_d       = 1'b1;
			connect_base = '0;
		end else if (!now_conn && link_q) begin
			link_d    = 1'b0;
			mode_base = ST_STANDBY;
			dt        = '0;
		end
		connect_d = link_d ? sat_add(connect_base, dt) : connect_base;
		charge_d  = (mode_base == ST_CHARGING) ? sat_add(charge_q, dt) : charge_q;
		time_over = charge_d > cfg.max_charge_ms;

		mode_d  = mode_base;
		fault_d = fault_q;
		robot_d = robot_q;
		priority if (too_hot) begin
			fault_d = FLT_TEMP;
			mode_d  = ST_ESTOP;
		end else if (time_over) begin
			fault_d = FLT_TIME;
			mode_d  = ST_ESTOP;
		end else if (bad_conn) begin
			fault_d = FLT_FLOW;
			mode_d  = ST_BADCONN;
		end else begin
			unique case (mode_base)
				ST_STANDBY: begin
					if (now_conn) mode_d = ST_CHECK;
				end
				ST_CHECK: begin
					if (now_conn) begin
						robot_d = cur_x > robot_on_x;
						mode_d  = ST_CHARGING;
					end else begin
						mode_d = ST_STANDBY;
					end
				end
				ST_CHARGING: begin
					if ((cur_x < thr_x) && (cur_x > cutoff_x)) mode_d = ST_CHARGED;
				end
				ST_CHARGED: begin
					if (!link_d) mode_d = ST_STANDBY;
				end
				ST_ESTOP: begin
					fault_d = FLT_NONE;
					mode_d  = ST_STANDBY;
				end
				ST_BADCONN: begin
					if (smp.voltage_mv < cfg.connect_min_mv) mode_d = ST_STANDBY;
				end
				default: begin
					mode_d = mode_base;
				end
			endcase
		end
	end

	// State registers, which double as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ST_STANDBY;
			link_q    <= 1'b0;
			robot_q   <= 1'b0;
			fault_q   <= FLT_NONE;
			charge_q  <= '0;
			connect_q <= '0;
		end else if (advance) begin
			mode_q    <= mode_d;
			link_q    <= link_d;
			robot_q   <= robot_d;
			fault_q   <= fault_d;
			charge_q  <= charge_d;
			connect_q <= connect_d;
		end
	end

	// Result fields straight from the state.
	always_comb begin
		res.charge_state    = mode_q;
		res.fault_code      = fault_q;
		res.is_connected    = link_q;
		res.is_charging     = (mode_q == ST_CHARGING);
		res.robot_powered   = robot_q;
		res.charge_time_ms  = charge_q;
		res.connect_time_ms = connect_q;
	end

`ifndef SYNTHESIS
	// Emergency stop always carries a temperature or charge time fault.
	a_estop_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ST_ESTOP) |-> ((fault_q == FLT_TEMP) || (fault_q == FLT_TIME)))
		else $error("emergency stop without a matching fault code");

	// Charging only happens while the link is up.
	a_charge_link: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ST_CHARGING) |-> link_q)
		else $error("charging state with link down");

	// The charge timer never goes backward.
	a_charge_mono: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (charge_q >= $past(charge_q)))
		else $error("charge timer decreased");

	// Without a transfer the state holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(mode_q) && $stable(charge_q) && $stable(connect_q)
			&& $stable(fault_q)))
		else $error("state changed without a transfer");
`endif

endmodule
